// ----- rtl/core/dnc_pkg.sv -----
// shared types and constants of the day number to calendar date converter
package dnc_pkg;

    localparam int FRAC_BITS  = 32;
    localparam int SEC_BITS   = FRAC_BITS + 6;
    localparam int MIN_BITS   = 11;
    localparam int NUM_STAGES = 15;

    localparam int unsigned DAY_OFFSET      = 134493;
    localparam int unsigned DAYS_400Y       = 146097;
    localparam int unsigned DAYS_100Y       = 36524;
    localparam int unsigned DAYS_4Y         = 1461;
    localparam int unsigned MINUTES_PER_DAY = 1440;
    localparam int unsigned BASE_YEAR       = 1600;
    localparam logic [31:0] ROUND_RESET     = 32'd4295;

    localparam logic [SEC_BITS:0] FULL_MINUTE = (SEC_BITS + 1)'(64'd60 << FRAC_BITS);

    typedef struct packed {
        logic signed [23:0]    day_whole;
        logic [FRAC_BITS-1:0]  day_part;
    } dnc_in_t;

    typedef struct packed {
        logic [14:0]          year_ad;
        logic [3:0]           month_num;
        logic [4:0]           day_of_month;
        logic [4:0]           hour_num;
        logic [5:0]           minute_num;
        logic [SEC_BITS-1:0]  second_fx;
    } dnc_out_t;

    typedef struct packed {
        logic [23:0]          day_num;
        logic [MIN_BITS-1:0]  minutes;
        logic [SEC_BITS-1:0]  second_fx;
    } dnc_front_t;

endpackage

// ----- rtl/core/dnc_front.sv -----
// fraction split into minutes and seconds, round up and day offset (stages 1 to 3)
module dnc_front
    import dnc_pkg::*;
(
    input  logic        aclk,
    input  logic        adv,
    input  dnc_in_t     in_data,
    input  logic [31:0] round_window,
    output dnc_front_t  front
);

    logic [FRAC_BITS+MIN_BITS-1:0] total_reg;
    logic signed [24:0]            day1_reg;
    logic [SEC_BITS-1:0]           sec2_reg;
    logic [MIN_BITS-1:0]           min2_reg;
    logic signed [24:0]            day2_reg;
    dnc_front_t                    front_reg;

    logic [SEC_BITS:0]   sec_sum;
    logic                round_up;
    logic                last_minute;
    logic signed [24:0]  day_sum;
    dnc_front_t          front_next;

    always_comb begin
        sec_sum     = {1'b0, sec2_reg} + (SEC_BITS + 1)'(round_window);
        round_up    = sec_sum > FULL_MINUTE;
        last_minute = min2_reg == MIN_BITS'(MINUTES_PER_DAY - 1);
        day_sum     = day2_reg + 25'(round_up && last_minute);
        if (round_up) begin
            front_next.minutes   = last_minute ? '0 : min2_reg + MIN_BITS'(1);
            front_next.second_fx = '0;
        end else begin
            front_next.minutes   = min2_reg;
            front_next.second_fx = sec2_reg;
        end
        front_next.day_num = day_sum[24] ? 24'd0 : day_sum[23:0];
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            total_reg <= (FRAC_BITS + MIN_BITS)'(in_data.day_part)
                         * (FRAC_BITS + MIN_BITS)'(MINUTES_PER_DAY);
            day1_reg  <= {in_data.day_whole[23], in_data.day_whole} + 25'(DAY_OFFSET);
            sec2_reg  <= SEC_BITS'(total_reg[FRAC_BITS-1:0]) * SEC_BITS'(60);
            min2_reg  <= total_reg[FRAC_BITS+MIN_BITS-1:FRAC_BITS];
            day2_reg  <= day1_reg;
            front_reg <= front_next;
        end
    end

    assign front = front_reg;

endmodule

// ----- rtl/core/dnc_clock.sv -----
// hour and minute split and time alignment (stages 4 to 15)
module dnc_clock
    import dnc_pkg::*;
(
    input  logic                 aclk,
    input  logic                 adv,
    input  logic [MIN_BITS-1:0]  minutes,
    input  logic [SEC_BITS-1:0]  second_in,
    output logic [4:0]           hour_num,
    output logic [5:0]           minute_num,
    output logic [SEC_BITS-1:0]  second_fx
);

    localparam int DELAY = NUM_STAGES - 4;

    typedef struct packed {
        logic [4:0]          hour;
        logic [5:0]          minute;
        logic [SEC_BITS-1:0] sec;
    } clk_t;

    logic [21:0]          hour_prod;
    logic [4:0]           hour4_reg;
    logic [MIN_BITS-1:0]  min4_reg;
    logic [SEC_BITS-1:0]  sec4_reg;
    logic [MIN_BITS-1:0]  minute_full;
    clk_t                 pipe_reg [DELAY];

    assign hour_prod   = 22'(minutes) * 22'd1093;
    assign minute_full = min4_reg - MIN_BITS'(hour4_reg) * MIN_BITS'(60);

    always_ff @(posedge aclk) begin
        if (adv) begin
            hour4_reg          <= hour_prod[20:16];
            min4_reg           <= minutes;
            sec4_reg           <= second_in;
            pipe_reg[0].hour   <= hour4_reg;
            pipe_reg[0].minute <= minute_full[5:0];
            pipe_reg[0].sec    <= sec4_reg;
            for (int i = 1; i < DELAY; i++) begin
                pipe_reg[i] <= pipe_reg[i-1];
            end
        end
    end

    assign hour_num   = pipe_reg[DELAY-1].hour;
    assign minute_num = pipe_reg[DELAY-1].minute;
    assign second_fx  = pipe_reg[DELAY-1].sec;

endmodule

// ----- rtl/core/dnc_date.sv -----
// gregorian date from days since 1600-03-01 (stages 4 to 15)
module dnc_date
    import dnc_pkg::*;
(
    input  logic        aclk,
    input  logic        adv,
    input  logic [23:0] day_num,
    output logic [14:0] year_ad,
    output logic [3:0]  month_num,
    output logic [4:0]  day_of_month
);

    localparam logic [12:0] RECIP_400Y  = 13'd7349;
    localparam logic [9:0]  RECIP_4Y    = 10'd717;
    localparam logic [15:0] RECIP_MONTH = 16'd34283;
    localparam int unsigned MONTH_NUM   = 30585;

    logic [10:0] start_tab [64];

    for (genvar g = 0; g < 64; g++) begin : g_start
        localparam int unsigned START = (MONTH_NUM * g) / 1000;
        assign start_tab[g] = 11'(START);
    end

    // stage 4
    logic [36:0] q400_prod;
    logic [5:0]  q4_reg;
    logic [23:0] d4_reg;
    // stage 5
    logic [23:0] r5_full;
    logic [5:0]  q5_reg;
    logic [18:0] r5_reg;
    // stage 6
    logic [5:0]  n400_reg;
    logic [17:0] r400_reg;
    // stage 7
    logic [1:0]  n100;
    logic [17:0] sub100;
    logic [17:0] r100_full;
    logic [15:0] r100_reg;
    logic [14:0] yb7_reg;
    // stage 8
    logic [25:0] q4y_prod;
    logic [4:0]  q8_reg;
    logic [15:0] r8_reg;
    logic [14:0] yb8_reg;
    // stage 9
    logic [15:0] t9_full;
    logic [4:0]  q9_reg;
    logic [11:0] t9_reg;
    logic [14:0] yb9_reg;
    // stage 10
    logic [10:0] r4_reg;
    logic [14:0] yb10_reg;
    // stage 11
    logic [1:0]  n1;
    logic [10:0] r4a_reg;
    logic [14:0] yb11_reg;
    // stage 12
    logic [26:0] m_prod;
    logic [5:0]  m12_reg;
    logic [10:0] r12_reg;
    logic [14:0] yb12_reg;
    // stage 13
    logic [20:0] tm_full;
    logic [15:0] tm_reg;
    logic [5:0]  m13_reg;
    logic [10:0] r13_reg;
    logic [14:0] yb13_reg;
    // stage 14
    logic [5:0]  m14_reg;
    logic [10:0] r14_reg;
    logic [14:0] yb14_reg;
    // stage 15
    logic [2:0]  yinc;
    logic [6:0]  month_full;
    logic [10:0] dom_full;
    logic [14:0] year_reg;
    logic [3:0]  month_reg;
    logic [4:0]  dom_reg;

    always_comb begin
        q400_prod = 37'(day_num) * 37'(RECIP_400Y);
        r5_full   = d4_reg - 24'(q4_reg) * 24'(DAYS_400Y);
        n100      = 2'(r400_reg >= 18'd36525) + 2'(r400_reg >= 18'd73049)
                    + 2'(r400_reg >= 18'd109573);
        case (n100)
            2'd0:    sub100 = 18'd0;
            2'd1:    sub100 = 18'(DAYS_100Y);
            2'd2:    sub100 = 18'(2 * DAYS_100Y);
            default: sub100 = 18'(3 * DAYS_100Y);
        endcase
        r100_full = r400_reg - sub100 - 18'd1;
        q4y_prod  = 26'(r100_reg) * 26'(RECIP_4Y);
        t9_full   = r8_reg - 16'(q8_reg) * 16'(DAYS_4Y);
        n1        = 2'(r4_reg >= 11'd366) + 2'(r4_reg >= 11'd731)
                    + 2'(r4_reg >= 11'd1096);
        m_prod    = 27'(r4a_reg) * 27'(RECIP_MONTH);
        tm_full   = 21'(r12_reg) * 21'd1000 - 21'(m12_reg) * 21'(MONTH_NUM);
        yinc      = 3'(m14_reg >= 6'd11) + 3'(m14_reg >= 6'd23)
                    + 3'(m14_reg >= 6'd35) + 3'(m14_reg >= 6'd47);
        month_full = 7'(m14_reg) + 7'd2 - 7'(yinc) * 7'd12;
        dom_full   = r14_reg - start_tab[m14_reg];
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            q4_reg   <= q400_prod[35:30];
            d4_reg   <= day_num;

            q5_reg   <= q4_reg;
            r5_reg   <= r5_full[18:0];

            if (r5_reg >= 19'(DAYS_400Y)) begin
                n400_reg <= q5_reg + 6'd1;
                r400_reg <= 18'(r5_reg - 19'(DAYS_400Y)) + 18'd1;
            end else begin
                n400_reg <= q5_reg;
                r400_reg <= r5_reg[17:0] + 18'd1;
            end

            r100_reg <= r100_full[15:0];
            yb7_reg  <= 15'(BASE_YEAR) + 15'(n400_reg) * 15'd400 + 15'(n100) * 15'd100;

            q8_reg   <= q4y_prod[24:20];
            r8_reg   <= r100_reg;
            yb8_reg  <= yb7_reg;

            q9_reg   <= q8_reg;
            t9_reg   <= t9_full[11:0];
            yb9_reg  <= yb8_reg;

            if (t9_reg >= 12'(DAYS_4Y)) begin
                r4_reg   <= 11'(t9_reg - 12'(DAYS_4Y)) + 11'd1;
                yb10_reg <= yb9_reg + 15'(q9_reg + 5'd1) * 15'd4;
            end else begin
                r4_reg   <= t9_reg[10:0] + 11'd1;
                yb10_reg <= yb9_reg + 15'(q9_reg) * 15'd4;
            end

            r4a_reg  <= r4_reg + 11'd30 + 11'(n1) * 11'd2;
            yb11_reg <= yb10_reg;

            m12_reg  <= m_prod[25:20];
            r12_reg  <= r4a_reg;
            yb12_reg <= yb11_reg;

            tm_reg   <= tm_full[15:0];
            m13_reg  <= m12_reg;
            r13_reg  <= r12_reg;
            yb13_reg <= yb12_reg;

            m14_reg  <= m13_reg + 6'(tm_reg >= 16'(MONTH_NUM));
            r14_reg  <= r13_reg;
            yb14_reg <= yb13_reg;

            year_reg  <= yb14_reg + 15'(yinc);
            month_reg <= month_full[3:0];
            dom_reg   <= dom_full[4:0];
        end
    end

    assign year_ad      = year_reg;
    assign month_num    = month_reg;
    assign day_of_month = dom_reg;

endmodule

// ----- rtl/core/dnc_skid.sv -----
// output register with one-entry skid stage
module dnc_skid
    import dnc_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     in_valid,
    input  dnc_out_t in_data,
    output logic     adv,
    output logic     m_valid,
    input  logic     m_ready,
    output dnc_out_t m_data
);

    logic     out_valid_reg;
    dnc_out_t out_data_reg;
    logic     skid_valid_reg;
    dnc_out_t skid_data_reg;
    logic     incoming;

    assign adv      = !skid_valid_reg;
    assign incoming = adv && in_valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_ready) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= incoming;
            end else begin
                out_valid_reg  <= incoming;
            end
        end else if (incoming) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_valid_reg || m_ready) begin
            if (skid_valid_reg) begin
                out_data_reg  <= skid_data_reg;
                skid_data_reg <= in_data;
            end else begin
                out_data_reg  <= in_data;
            end
        end else if (incoming) begin
            skid_data_reg <= in_data;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule

// ----- rtl/core/day_number_to_calendar_date.sv -----
// top level of the day number to calendar date converter
//
//   channel   direction  handshake          payload
//   s_        in         s_valid/s_ready    dnc_in_t  (day_whole, day_part)
//   m_        out        m_valid/m_ready    dnc_out_t (date and time of day)
//   cfg_      in         cfg_wr_en          round_window, no read-back
//
// one request per cycle while s_ready is high; each result passes through
// 15 pipeline stages plus the output register
// reset clears stage valids, output and skid state, round_window back to 4295
// when the output stalls one more result lands in the skid entry, then the
// whole pipeline holds and s_ready drops until the output is taken
module day_number_to_calendar_date
    import dnc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  dnc_in_t     s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output dnc_out_t    m_data,
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data
);

    logic [31:0]           round_window_reg;
    logic [NUM_STAGES-1:0] vld_reg;
    logic                  adv;
    dnc_front_t            front;
    dnc_out_t              result;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            round_window_reg <= ROUND_RESET;
        end else if (cfg_wr_en) begin
            round_window_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[NUM_STAGES-2:0], s_valid};
        end
    end

    assign s_ready = adv;

    dnc_front u_front (
        .aclk         (aclk),
        .adv          (adv),
        .in_data      (s_data),
        .round_window (round_window_reg),
        .front        (front)
    );

    dnc_date u_date (
        .aclk         (aclk),
        .adv          (adv),
        .day_num      (front.day_num),
        .year_ad      (result.year_ad),
        .month_num    (result.month_num),
        .day_of_month (result.day_of_month)
    );

    dnc_clock u_clock (
        .aclk       (aclk),
        .adv        (adv),
        .minutes    (front.minutes),
        .second_in  (front.second_fx),
        .hour_num   (result.hour_num),
        .minute_num (result.minute_num),
        .second_fx  (result.second_fx)
    );

    dnc_skid u_skid (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (vld_reg[NUM_STAGES-1]),
        .in_data  (result),
        .adv      (adv),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule
